[hw/rtl/rtph_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtph_pkg
// shared types and constants of the run-time profiler histogram unit
// ----------------------------------------------------------------------------
package rtph_pkg;

	// field widths of the stream items
	localparam int unsigned CMD_W       = 2;
	localparam int unsigned STAMP_W     = 32;
	localparam int unsigned RIDX_W      = 4;
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned SUM_W       = 64;
	localparam int unsigned CNT_W       = 32;
	localparam int unsigned BIDX_W      = 4;
	localparam int unsigned USED_W      = 5;
	localparam int unsigned IN_TDATA_W  = 72;
	localparam int unsigned OUT_TDATA_W = 240;
	localparam int unsigned ENTRY_W     = TIME_W + CNT_W;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_RECORD = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STATS,
		ST_SEARCH,
		ST_COMPARE,
		ST_HIT,
		ST_NEW,
		ST_DROP,
		ST_READ,
		ST_READ_DATA,
		ST_CLEAR,
		ST_ZERO,
		ST_FINISH
	} state_t;

	// bin store read address source
	typedef enum logic [1:0] {
		RD_IDX,
		RD_IDX_NEXT,
		RD_RIDX
	} rd_sel_t;

	// bin fields of the result
	typedef enum logic [2:0] {
		RES_HIT,
		RES_NEW,
		RES_DROP,
		RES_READ_HIT,
		RES_READ_MISS,
		RES_ZERO
	} res_sel_t;

	// commands from controller to datapath
	typedef struct packed {
		logic     latch;
		logic     stats_upd;
		logic     idx_clr;
		logic     idx_inc;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     wr_en;
		logic     wr_new;
		logic     res_ld;
		res_sel_t res_sel;
		logic     clear;
		logic     out_ld;
	} ctl_t;

	// status from datapath to controller
	typedef struct packed {
		logic fill_nz;
		logic room;
		logic next_lt_fill;
		logic match;
		logic ridx_ok;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

[hw/rtl/run_time_profiler_histogram_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// run_time_profiler_histogram_unit
// run-time profiler with a histogram of distinct run lengths
// ----------------------------------------------------------------------------
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid / s_tready  tdata: start, stop, read_index; tuser: command
// m_*      out  m_tvalid / m_tready  tdata: statistics and bin fields of the item
//
// one item is taken at a time and always gives one result item
// record: the bin search reads one bin per cycle
//   through the single read port of the bin store, stopping at the first match
// read: a filled bin is read from the bin store, an unused bin gives zero bin time and count;
//   clear and unused codes go straight to the finishing step
// the result sits in an output register, so the next item is taken while it waits;
//   only the finishing step of an item stalls while the previous result is not taken
// reset clears all statistics and the fill count; bin contents need no clearing
//
module run_time_profiler_histogram_unit #(
	parameter int unsigned BINS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,

	// input items
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// start_stamp[31:0], stop_stamp[63:32], read_index[67:64], zero fill
	input  wire logic [rtph_pkg::IN_TDATA_W-1:0]     s_tdata,
	// command[1:0]
	input  wire logic [rtph_pkg::CMD_W-1:0]          s_tuser,

	// result items
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// elapsed[31:0], total_time[95:32], run_count[127:96], min_elapsed[159:128],
	// bin_index[163:160], bin_time[195:164], bin_count[227:196],
	// bins_used[232:228], bin_dropped[233], zero fill
	output logic      [rtph_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	// command and status between sequencer and datapath
	rtph_pkg::ctl_t ctl;
	rtph_pkg::sts_t sts;

	// sequencer: command decode, bin search steps, result handoff
	rtph_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.sts      (sts),
		.ctl      (ctl)
	);

	// datapath: statistics registers, bin store, output register
	rtph_dp #(
		.BINS (BINS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

[hw/rtl/rtph_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtph_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rtph_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

[hw/rtl/rtph_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtph_ctrl
// sequencer of the profiler: accepts items and steps the datapath
// ----------------------------------------------------------------------------
module rtph_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [rtph_pkg::CMD_W-1:0] s_tuser,
	input  wire rtph_pkg::sts_t       sts,
	output rtph_pkg::ctl_t            ctl
);

	rtph_pkg::state_t state_q;
	rtph_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtph_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		ctl        = '0;
		ctl.rd_sel = rtph_pkg::RD_IDX;
		ctl.res_sel = rtph_pkg::RES_ZERO;
		s_tready   = 1'b0;
		case (state_q)
			rtph_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.latch = 1'b1;
					case (rtph_pkg::cmd_t'(s_tuser))
						rtph_pkg::CMD_RECORD: state_d = rtph_pkg::ST_STATS;
						rtph_pkg::CMD_READ:   state_d = rtph_pkg::ST_READ;
						rtph_pkg::CMD_CLEAR:  state_d = rtph_pkg::ST_CLEAR;
						default:              state_d = rtph_pkg::ST_ZERO;
					endcase
				end
			end
			rtph_pkg::ST_STATS: begin
				ctl.stats_upd = 1'b1;
				ctl.idx_clr   = 1'b1;
				state_d       = rtph_pkg::ST_SEARCH;
			end
			rtph_pkg::ST_SEARCH: begin
				if (sts.fill_nz) begin
					ctl.rd_en = 1'b1;
					state_d   = rtph_pkg::ST_COMPARE;
				end else if (sts.room) begin
					state_d = rtph_pkg::ST_NEW;
				end else begin
					state_d = rtph_pkg::ST_DROP;
				end
			end
			rtph_pkg::ST_COMPARE: begin
				if (sts.match) begin
					state_d = rtph_pkg::ST_HIT;
				end else if (sts.next_lt_fill) begin
					ctl.idx_inc = 1'b1;
					ctl.rd_en   = 1'b1;
					ctl.rd_sel  = rtph_pkg::RD_IDX_NEXT;
				end else if (sts.room) begin
					state_d = rtph_pkg::ST_NEW;
				end else begin
					state_d = rtph_pkg::ST_DROP;
				end
			end
			rtph_pkg::ST_HIT: begin
				ctl.wr_en   = 1'b1;
				ctl.res_ld  = 1'b1;
				ctl.res_sel = rtph_pkg::RES_HIT;
				state_d     = rtph_pkg::ST_FINISH;
			end
			rtph_pkg::ST_NEW: begin
				ctl.wr_en   = 1'b1;
				ctl.wr_new  = 1'b1;
				ctl.res_ld  = 1'b1;
				ctl.res_sel = rtph_pkg::RES_NEW;
				state_d     = rtph_pkg::ST_FINISH;
			end
			rtph_pkg::ST_DROP: begin
				ctl.res_ld  = 1'b1;
				ctl.res_sel = rtph_pkg::RES_DROP;
				state_d     = rtph_pkg::ST_FINISH;
			end
			rtph_pkg::ST_READ: begin
				if (sts.ridx_ok) begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = rtph_pkg::RD_RIDX;
					state_d    = rtph_pkg::ST_READ_DATA;
				end else begin
					ctl.res_ld  = 1'b1;
					ctl.res_sel = rtph_pkg::RES_READ_MISS;
					state_d     = rtph_pkg::ST_FINISH;
				end
			end
			rtph_pkg::ST_READ_DATA: begin
				ctl.res_ld  = 1'b1;
				ctl.res_sel = rtph_pkg::RES_READ_HIT;
				state_d     = rtph_pkg::ST_FINISH;
			end
			rtph_pkg::ST_CLEAR: begin
				ctl.clear   = 1'b1;
				ctl.res_ld  = 1'b1;
				ctl.res_sel = rtph_pkg::RES_ZERO;
				state_d     = rtph_pkg::ST_FINISH;
			end
			rtph_pkg::ST_ZERO: begin
				ctl.res_ld  = 1'b1;
				ctl.res_sel = rtph_pkg::RES_ZERO;
				state_d     = rtph_pkg::ST_FINISH;
			end
			rtph_pkg::ST_FINISH: begin
				if (!sts.out_busy) begin
					ctl.out_ld = 1'b1;
					state_d    = rtph_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rtph_pkg::ST_IDLE;
			end
		endcase
	end

	// every compare step sees data read in the cycle before
	a_cmp_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rtph_pkg::ST_COMPARE |-> $past(ctl.rd_en))
		else $error("compare without a preceding bin read");

	// a hit always writes back the bin it just compared
	a_hit_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rtph_pkg::ST_HIT |-> $past(state_q) == rtph_pkg::ST_COMPARE
			&& $past(sts.match))
		else $error("bin update without a match");

endmodule
`default_nettype wire

[hw/rtl/rtph_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtph_dp
// datapath of the profiler: statistics, bin store, search index, result
// ----------------------------------------------------------------------------
module rtph_dp #(
	parameter int unsigned BINS = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire rtph_pkg::ctl_t                   ctl,
	output rtph_pkg::sts_t                        sts,
	input  wire logic [rtph_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic      [rtph_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int unsigned AW = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int unsigned CW = $clog2(BINS + 1);

	// latched item
	logic [rtph_pkg::TIME_W-1:0] run_q;
	logic [rtph_pkg::RIDX_W-1:0] ridx_q;

	// statistics
	logic [rtph_pkg::TIME_W-1:0] last_q;
	logic [rtph_pkg::SUM_W-1:0]  sum_q;
	logic [rtph_pkg::CNT_W-1:0]  runs_q;
	logic [rtph_pkg::TIME_W-1:0] min_q;
	logic [CW-1:0]               fill_q;

	// search
	logic [AW-1:0] idx_q;
	logic [CW:0]   idx_nxt;

	// bin store
	logic [AW-1:0]                rd_addr;
	logic [AW-1:0]                wr_addr;
	logic [rtph_pkg::ENTRY_W-1:0] wr_data;
	logic [rtph_pkg::ENTRY_W-1:0] rd_data;
	logic [rtph_pkg::TIME_W-1:0]  rd_val;
	logic [rtph_pkg::CNT_W-1:0]   rd_tally;
	logic [rtph_pkg::CNT_W-1:0]   tally_inc;

	// result bin fields
	logic [rtph_pkg::BIDX_W-1:0] res_idx_q;
	logic [rtph_pkg::TIME_W-1:0] res_time_q;
	logic [rtph_pkg::CNT_W-1:0]  res_cnt_q;
	logic                        res_drop_q;

	logic                        out_vld_q;
	logic [rtph_pkg::SUM_W:0]    sum_w;

	assign idx_nxt   = (CW + 1)'(idx_q) + (CW + 1)'(1);
	assign rd_val    = rd_data[rtph_pkg::TIME_W-1:0];
	assign rd_tally  = rd_data[rtph_pkg::ENTRY_W-1:rtph_pkg::TIME_W];
	assign tally_inc = (rd_tally == '1) ? rd_tally : rd_tally + 1'b1;
	assign sum_w     = {1'b0, sum_q} + (rtph_pkg::SUM_W + 1)'(run_q);

	always_comb begin
		case (ctl.rd_sel)
			rtph_pkg::RD_IDX:      rd_addr = idx_q;
			rtph_pkg::RD_IDX_NEXT: rd_addr = idx_nxt[AW-1:0];
			rtph_pkg::RD_RIDX:     rd_addr = AW'(ridx_q);
			default:               rd_addr = idx_q;
		endcase
	end

	assign wr_addr = ctl.wr_new ? fill_q[AW-1:0] : idx_q;
	assign wr_data = ctl.wr_new ? {rtph_pkg::CNT_W'(1), run_q} : {tally_inc, rd_val};

	rtph_ram #(
		.WIDTH (rtph_pkg::ENTRY_W),
		.DEPTH (BINS)
	) u_bins (
		.clk     (clk),
		.wr_en   (ctl.wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (ctl.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// status
	assign sts.fill_nz      = fill_q != '0;
	assign sts.room         = fill_q < CW'(BINS);
	assign sts.next_lt_fill = idx_nxt < (CW + 1)'(fill_q);
	assign sts.match        = rd_val == run_q;
	assign sts.ridx_ok      = 32'(ridx_q) < 32'(fill_q);
	assign sts.out_busy     = out_vld_q && !m_tready;

	// item latch, search index, result fields
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			run_q  <= s_tdata[63:32] - s_tdata[31:0];
			ridx_q <= s_tdata[67:64];
		end
		if (ctl.idx_clr) begin
			idx_q <= '0;
		end else if (ctl.idx_inc) begin
			idx_q <= idx_nxt[AW-1:0];
		end
		if (ctl.res_ld) begin
			res_drop_q <= (ctl.res_sel == rtph_pkg::RES_DROP);
			case (ctl.res_sel)
				rtph_pkg::RES_HIT: begin
					res_idx_q  <= rtph_pkg::BIDX_W'(idx_q);
					res_time_q <= rd_val;
					res_cnt_q  <= tally_inc;
				end
				rtph_pkg::RES_NEW: begin
					res_idx_q  <= rtph_pkg::BIDX_W'(fill_q);
					res_time_q <= run_q;
					res_cnt_q  <= rtph_pkg::CNT_W'(1);
				end
				rtph_pkg::RES_DROP: begin
					res_idx_q  <= '0;
					res_time_q <= '0;
					res_cnt_q  <= '0;
				end
				rtph_pkg::RES_READ_HIT: begin
					res_idx_q  <= ridx_q;
					res_time_q <= rd_val;
					res_cnt_q  <= rd_tally;
				end
				rtph_pkg::RES_READ_MISS: begin
					res_idx_q  <= ridx_q;
					res_time_q <= '0;
					res_cnt_q  <= '0;
				end
				default: begin
					res_idx_q  <= '0;
					res_time_q <= '0;
					res_cnt_q  <= '0;
				end
			endcase
		end
	end

	// statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			sum_q  <= '0;
			runs_q <= '0;
			min_q  <= '1;
			fill_q <= '0;
		end else if (ctl.clear) begin
			last_q <= '0;
			sum_q  <= '0;
			runs_q <= '0;
			min_q  <= '1;
			fill_q <= '0;
		end else begin
			if (ctl.stats_upd) begin
				last_q <= run_q;
				sum_q  <= sum_w[rtph_pkg::SUM_W] ? '1 : sum_w[rtph_pkg::SUM_W-1:0];
				if (runs_q != '1) begin
					runs_q <= runs_q + 1'b1;
				end
				if (run_q < min_q) begin
					min_q <= run_q;
				end
			end
			if (ctl.wr_en && ctl.wr_new) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.out_ld) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_ld) begin
			m_tdata <= {6'd0, res_drop_q, rtph_pkg::USED_W'(fill_q), res_cnt_q, res_time_q,
				res_idx_q, min_q, runs_q, sum_q, last_q};
		end
	end

	assign m_tvalid = out_vld_q;

	// a new bin is only opened while one is free
	a_new_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en && ctl.wr_new |-> fill_q < CW'(BINS))
		else $error("new bin opened on a full histogram");

	// a finished result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_ld |-> !(out_vld_q && !m_tready))
		else $error("result overwritten while stalled");

	// after a recorded run the minimum is no larger than that run and the run count is not zero
	a_min_le_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.stats_upd && !ctl.clear |=> min_q <= last_q && runs_q != '0)
		else $error("minimum or run count not updated");

endmodule
`default_nettype wire

[tb/sv/rtph_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rtph_checker
// predicts the result item of every accepted command item and compares it,
// field by field and in order, with the result items leaving the unit
// ----------------------------------------------------------------------------
module rtph_checker #(
	parameter int unsigned BINS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	input  wire logic                                s_tready,
	input  wire logic [rtph_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  wire logic [rtph_pkg::CMD_W-1:0]          s_tuser,
	input  wire logic                                m_tvalid,
	input  wire logic                                m_tready,
	input  wire logic [rtph_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output int                                       fail_count,
	output int                                       pending
);
	import rtph_pkg::*;

	// laid out as in m_tdata: last member in the lowest bits
	typedef struct packed {
		logic              dropped;
		logic [USED_W-1:0] used;
		logic [CNT_W-1:0]  bin_count;
		logic [TIME_W-1:0] bin_time;
		logic [BIDX_W-1:0] bin_index;
		logic [TIME_W-1:0] minimum;
		logic [CNT_W-1:0]  runs;
		logic [SUM_W-1:0]  total;
		logic [TIME_W-1:0] elapsed;
	} profile_t;

	logic [TIME_W-1:0] last_run;
	logic [SUM_W-1:0]  time_sum;
	logic [CNT_W-1:0]  runs_seen;
	logic [TIME_W-1:0] shortest;
	logic [USED_W-1:0] filled;
	logic [TIME_W-1:0] bin_value [BINS];
	logic [CNT_W-1:0]  bin_tally [BINS];

	profile_t stats_due [$];
	profile_t seen_stats;
	profile_t want_stats;

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [SUM_W-1:0] got,
		input logic [SUM_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	function automatic void clear_stats();
		last_run  = '0;
		time_sum  = '0;
		runs_seen = '0;
		shortest  = '1;
		filled    = '0;
	endfunction

	// applies one command to the statistics and returns the result it gives
	function automatic profile_t predict_profile(input logic [CMD_W-1:0] code,
		input logic [STAMP_W-1:0] t_start, input logic [STAMP_W-1:0] t_stop,
		input logic [RIDX_W-1:0] ridx);
		profile_t r;
		logic [TIME_W-1:0] run;
		logic [SUM_W:0] sum;
		int pos;
		r = '0;
		pos = -1;
		case (code)
		CMD_RECORD: begin
			run = t_stop - t_start;
			last_run = run;
			sum = {1'b0, time_sum} + run;
			time_sum = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
			if (runs_seen != '1)
				runs_seen = runs_seen + 1'b1;
			if (run < shortest)
				shortest = run;
			// first matching bin wins
			for (int i = 0; i < BINS; i++) begin
				if (pos < 0 && i < filled && bin_value[i] == run)
					pos = i;
			end
			if (pos >= 0) begin
				if (bin_tally[pos] != '1)
					bin_tally[pos] = bin_tally[pos] + 1'b1;
				r.bin_index = pos[BIDX_W-1:0];
				r.bin_time  = bin_value[pos];
				r.bin_count = bin_tally[pos];
			end else if (filled < BINS) begin
				bin_value[filled] = run;
				bin_tally[filled] = 1;
				r.bin_index = filled[BIDX_W-1:0];
				r.bin_time  = run;
				r.bin_count = 1;
				filled = filled + 1'b1;
			end else begin
				// histogram full: value not filed
				r.dropped = 1'b1;
			end
		end
		CMD_READ: begin
			r.bin_index = ridx;
			if (ridx < filled) begin
				r.bin_time  = bin_value[ridx];
				r.bin_count = bin_tally[ridx];
			end
		end
		CMD_CLEAR: clear_stats();
		default: ;
		endcase
		r.elapsed = last_run;
		r.total   = time_sum;
		r.runs    = runs_seen;
		r.minimum = shortest;
		r.used    = filled;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_stats();
			stats_due.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			// a result can never leave on the edge its command enters, so check first
			if (m_tvalid && m_tready) begin
				seen_stats = profile_t'(m_tdata[$bits(profile_t)-1:0]);
				if (stats_due.size() == 0) begin
					report_mismatch($sformatf("result item with nothing pending, elapsed 0x%0h",
						seen_stats.elapsed));
				end else begin
					want_stats = stats_due.pop_front();
					check_field("elapsed", seen_stats.elapsed, want_stats.elapsed);
					check_field("total_time", seen_stats.total, want_stats.total);
					check_field("run_count", seen_stats.runs, want_stats.runs);
					check_field("min_elapsed", seen_stats.minimum, want_stats.minimum);
					check_field("bin_index", seen_stats.bin_index, want_stats.bin_index);
					check_field("bin_time", seen_stats.bin_time, want_stats.bin_time);
					check_field("bin_count", seen_stats.bin_count, want_stats.bin_count);
					check_field("bins_used", seen_stats.used, want_stats.used);
					check_field("bin_dropped", seen_stats.dropped, want_stats.dropped);
				end
			end
			if (s_tvalid && s_tready)
				stats_due.push_back(predict_profile(s_tuser, s_tdata[STAMP_W-1:0],
					s_tdata[2*STAMP_W-1:STAMP_W], s_tdata[2*STAMP_W+RIDX_W-1:2*STAMP_W]));
			pending <= stats_due.size();
		end
	end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the run-time profiler histogram unit: a directed
// opening over the edge cases, then random commands with bursty idling on
// both streams and one long output hold-off; rtph_checker does the checking
// ----------------------------------------------------------------------------
module tb;
	import rtph_pkg::*;

	localparam int unsigned BINS         = 16;
	localparam int unsigned RANDOM_ITEMS = 400;
	localparam int unsigned POOL_N       = 20;
	// long output hold-off, lets the unit fill up and stall its input
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned HOLD_AT      = 150;
	// cycles with no item accepted on either stream before giving up
	localparam int unsigned QUIET_LIMIT  = 2000;
	// drain well past the slowest record command
	localparam int unsigned DRAIN_CYCLES = 2 * BINS + 8;
	// code outside the command set, must leave the state alone
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic [CMD_W-1:0]       s_tuser  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int          fail_count;
	int          pending;
	int unsigned taken        = 0;
	int unsigned quiet_cycles = 0;
	bit          calm         = 1'b0;
	logic [TIME_W-1:0] run_pool [POOL_N];

	run_time_profiler_histogram_unit #(
		.BINS(BINS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	rtph_checker #(
		.BINS(BINS)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// offers one command item and returns on the edge that accepts it;
	// gaps only in every other block of 40 items and never in the tail
	task automatic offer(input logic [CMD_W-1:0] code, input logic [STAMP_W-1:0] t_start,
		input logic [STAMP_W-1:0] t_stop, input logic [RIDX_W-1:0] ridx);
		if (!calm && (taken / 40) % 2 == 0 && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W - RIDX_W - 2 * STAMP_W){1'b0}}, ridx, t_stop, t_start};
		s_tuser  <= code;
		do @(posedge clk); while (!s_tready);
		taken++;
	endtask

	// command stimulus
	initial begin
		logic [STAMP_W-1:0] t0;
		logic [TIME_W-1:0] run;
		int pick;
		foreach (run_pool[k])
			run_pool[k] = $urandom;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty histogram and the unused code on the reset state
		offer(CMD_READ, '0, '0, 4'd0);
		offer(CMD_UNUSED, $urandom, $urandom, 4'hf);
		// zero length, then a wrapping stop that gives all ones, then both again as hits
		offer(CMD_RECORD, '0, '0, 4'd0);
		offer(CMD_RECORD, 32'h1, 32'h0, 4'hf);
		offer(CMD_RECORD, '1, '1, 4'd0);
		offer(CMD_RECORD, '0, '1, 4'd0);
		offer(CMD_READ, '0, '0, 4'd1);
		// read beyond the filled bins
		offer(CMD_READ, '1, '1, 4'd15);
		// fill every remaining bin with distinct lengths
		for (int k = 1; k <= 14; k++) begin
			t0 = $urandom;
			offer(CMD_RECORD, t0, t0 + k * 32'h1111_1111, 4'd0);
		end
		// no match and no free bin: dropped
		offer(CMD_RECORD, 32'h5, 32'h3, 4'd0);
		offer(CMD_READ, '0, '0, 4'd15);
		offer(CMD_CLEAR, $urandom, $urandom, RIDX_W'($urandom_range(0, 15)));
		offer(CMD_READ, '0, '0, 4'd0);

		// mostly records from a small pool so bins get hit, filled and overflowed;
		// clears are rare enough that the histogram usually fills in between
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= RANDOM_ITEMS - 60);
			pick = $urandom_range(0, 99);
			t0 = $urandom;
			if (pick < 64) begin
				if ($urandom_range(0, 5) == 0)
					run = $urandom;
				else
					run = run_pool[$urandom_range(0, POOL_N - 1)];
				offer(CMD_RECORD, t0, t0 + run, RIDX_W'($urandom_range(0, 15)));
			end else if (pick < 93) begin
				offer(CMD_READ, t0, $urandom, RIDX_W'($urandom_range(0, 15)));
			end else if (pick < 98) begin
				offer(CMD_UNUSED, t0, $urandom, RIDX_W'($urandom_range(0, 15)));
			end else begin
				offer(CMD_CLEAR, t0, $urandom, RIDX_W'($urandom_range(0, 15)));
			end
		end
		s_tvalid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// result side backpressure: one long hold-off, random stalls, calm blocks and tail
	initial begin
		bit held;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && taken >= HOLD_AT) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && (taken / 40) % 3 != 2 && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule
